FILE: rtl/fir_filter_16_tap_defines.svh
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_16_TAP_DEFINES_SVH
`define FIR_FILTER_16_TAP_DEFINES_SVH

// same-cycle implication
`define FIR16_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIR16_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fir16_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Register map, fixed widths, reset values and shared control types.
// ----------------------------------------------------------------------------
`default_nettype none

package fir16_pkg;

  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 64;
  localparam int NUM_GROUPS      = 4;
  localparam int SLOTS_PER_GROUP = 4;
  localparam int SLOT_BITS       = 16;
  localparam int NUM_COEF_SLOTS  = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int SLOT_SEL_BITS   = 4;   // selects one of the 16 slots
  localparam int TAP_IDX_BITS    = 6;   // holds any tap number up to 63
  localparam int OUT_BITS        = 16;
  localparam int SHIFT_BITS      = 4;

  localparam logic [SHIFT_BITS-1:0] RESET_SHIFT = SHIFT_BITS'(7);

  // taps 0..15 = 0,0,0,0, 3,8,16,22, 23,19,12,5, 1,0,0,0
  localparam logic [CFG_DATA_BITS-1:0] COEF_RESET [NUM_GROUPS] = '{
    64'h0000_0000_0000_0000,
    64'h0016_0010_0008_0003,
    64'h0005_000C_0013_0017,
    64'h0000_0000_0000_0001
  };

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE = 3'd0,
    REG_COEF0  = 3'd1,
    REG_COEF1  = 3'd2,
    REG_COEF2  = 3'd3,
    REG_COEF3  = 3'd4,
    REG_SHIFT  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clear;  // zero the accumulator
    logic load;   // take a new sample / coefficient pair
    logic step;   // consume one sample bit
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/fir_filter_16_tap.sv
// ----------------------------------------------------------------------------
// 16-tap FIR filter
// Direct-form FIR over unsigned samples, computed by one bit-serial MAC.
// ----------------------------------------------------------------------------
// An accepted beat starts the MAC state, which steps through each sample bit of
//   every tap; the finish state then loads the output register (m_axis_tvalid).
// Beats are taken only in idle, so none while a sum is in work: the single
//   bit-serial MAC adder takes one sample bit of one tap per cycle.
// Reset: rst_ni clears the delay line to zero, loads the default coefficients,
//   enable=1, shift=7, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fir_filter_16_tap_defines.svh"

module fir_filter_16_tap #(
  parameter int TAPS        = 16,
  parameter int SAMPLE_BITS = 12,
  parameter int COEF_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  // configuration writes, taken on any edge with cfg_we_i high
  input  wire logic                                  cfg_we_i,
  input  wire logic [fir16_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [fir16_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,

  // sample stream
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample, zero pad

  // result stream
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [fir16_pkg::OUT_BITS-1:0]             m_axis_tdata   // filtered
);

  localparam int TAP_W = $clog2(TAPS);
  localparam int BIT_W = $clog2(SAMPLE_BITS);
  // signed coef x unsigned sample, plus growth for the tap sum
  localparam int ACC_W = COEF_BITS + SAMPLE_BITS + $clog2(TAPS);
  localparam int GROUP_BITS = fir16_pkg::CFG_DATA_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                                 en_q;
  logic [GROUP_BITS-1:0]                coef_q [fir16_pkg::NUM_GROUPS];
  logic [fir16_pkg::SHIFT_BITS-1:0]     shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      shift_q <= fir16_pkg::RESET_SHIFT;
      for (int g = 0; g < fir16_pkg::NUM_GROUPS; g++) begin
        coef_q[g] <= fir16_pkg::COEF_RESET[g];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fir16_pkg::REG_ENABLE: en_q      <= cfg_wdata_i[0];
        fir16_pkg::REG_COEF0:  coef_q[0] <= cfg_wdata_i;
        fir16_pkg::REG_COEF1:  coef_q[1] <= cfg_wdata_i;
        fir16_pkg::REG_COEF2:  coef_q[2] <= cfg_wdata_i;
        fir16_pkg::REG_COEF3:  coef_q[3] <= cfg_wdata_i;
        fir16_pkg::REG_SHIFT:  shift_q   <= cfg_wdata_i[fir16_pkg::SHIFT_BITS-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: per tap, SAMPLE_BITS MAC steps; the window rotates at each tap
  // end so the next tap's sample always sits in win_q[1] when it is loaded.
  // --------------------------------------------------------------------------
  fir16_pkg::state_e    state_q, state_d;
  logic [TAP_W-1:0]     tap_q, tap_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  fir16_pkg::mac_ctrl_t mac_ctrl;
  logic                 accept;
  logic                 rotate;
  logic                 out_load;
  logic                 out_free;
  logic                 out_valid_q;
  logic                 tap_last;
  logic                 bit_last;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign tap_last = (tap_q == TAP_W'(TAPS - 1));
  assign bit_last = (bit_q == BIT_W'(SAMPLE_BITS - 1));

  always_comb begin
    state_d       = state_q;
    tap_d         = tap_q;
    bit_d         = bit_q;
    mac_ctrl      = '0;
    rotate        = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      fir16_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mac_ctrl.clear = 1'b1;
          mac_ctrl.load  = 1'b1;
          tap_d          = '0;
          bit_d          = '0;
          state_d        = fir16_pkg::ST_MAC;
        end
      end
      fir16_pkg::ST_MAC: begin
        mac_ctrl.step = 1'b1;
        bit_d         = BIT_W'(bit_q + 1'b1);
        if (bit_last) begin
          bit_d         = '0;
          mac_ctrl.load = 1'b1;
          rotate        = 1'b1;
          if (tap_last) begin
            tap_d   = '0;
            state_d = fir16_pkg::ST_FIN;
          end else begin
            tap_d = TAP_W'(tap_q + 1'b1);
          end
        end
      end
      fir16_pkg::ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = fir16_pkg::ST_IDLE;
        end
      end
      default: state_d = fir16_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fir16_pkg::ST_IDLE;
      tap_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      bit_q   <= bit_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sample window: win_q[0] is the current sample, win_q[1..] the delay line.
  // A new beat shifts in; each tap end rotates by one, TAPS rotations per item.
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] win_q [TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      win_q[0] <= s_axis_tdata[SAMPLE_BITS-1:0];
      for (int i = 1; i < TAPS; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end else if (rotate) begin
      for (int i = 0; i < TAPS; i++) begin
        win_q[i] <= win_q[(i + 1) % TAPS];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient select: tap 0 at accept, else the tap after the current one.
  // Taps past the 16 register slots read as zero.
  // --------------------------------------------------------------------------
  logic [fir16_pkg::NUM_GROUPS*GROUP_BITS-1:0] coef_flat;
  logic [fir16_pkg::TAP_IDX_BITS-1:0]          coef_idx;
  logic [fir16_pkg::SLOT_BITS-1:0]             coef_slot;
  logic [ACC_W-1:0]                            coef_ext;
  logic [SAMPLE_BITS-1:0]                      mac_sample;

  always_comb begin
    for (int g = 0; g < fir16_pkg::NUM_GROUPS; g++) begin
      coef_flat[g*GROUP_BITS +: GROUP_BITS] = coef_q[g];
    end
    coef_idx = accept ? '0
                      : fir16_pkg::TAP_IDX_BITS'(fir16_pkg::TAP_IDX_BITS'(tap_q) + 1'b1);
    coef_slot = '0;
    if (coef_idx < fir16_pkg::TAP_IDX_BITS'(fir16_pkg::NUM_COEF_SLOTS)) begin
      coef_slot = coef_flat[coef_idx[fir16_pkg::SLOT_SEL_BITS-1:0] * fir16_pkg::SLOT_BITS
                            +: fir16_pkg::SLOT_BITS];
    end
    coef_ext   = ACC_W'($signed(coef_slot[COEF_BITS-1:0]));
    mac_sample = accept ? s_axis_tdata[SAMPLE_BITS-1:0] : win_q[1];
  end

  logic [ACC_W-1:0] acc;

  fir16_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (mac_sample),
    .coef_i   (coef_ext),
    .acc_o    (acc)
  );

  // --------------------------------------------------------------------------
  // Output register: arithmetic shift of the sum (floor), low 16 bits kept;
  // bypass sends the raw sample, which is back in win_q[0] after the rotations.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]          acc_sh;
  logic [fir16_pkg::OUT_BITS-1:0]   out_d;
  logic [fir16_pkg::OUT_BITS-1:0]   out_data_q;

  always_comb begin
    acc_sh = $signed(acc) >>> shift_q;
    out_d  = en_q ? acc_sh[fir16_pkg::OUT_BITS-1:0] : fir16_pkg::OUT_BITS'(win_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FIR16_ASSERT_NXT(a_accept_starts_mac, accept, state_q == fir16_pkg::ST_MAC, "beat accepted but MAC did not start")
  `FIR16_ASSERT_IMP(a_tap_in_range, state_q == fir16_pkg::ST_MAC, tap_q <= TAP_W'(TAPS - 1), "tap counter out of range")
  `FIR16_ASSERT_NXT(a_fin_delivers, (state_q == fir16_pkg::ST_FIN) && out_free, out_valid_q && (state_q == fir16_pkg::ST_IDLE), "finished sum not delivered")

endmodule

`default_nettype wire

FILE: rtl/fir16_mac.sv
// ----------------------------------------------------------------------------
// FIR bit-serial multiply-accumulate
// Sample shifts out LSB first; coefficient shifts left; one add per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module fir16_mac #(
  parameter int SAMPLE_BITS = 12,
  parameter int ACC_W       = 32
) (
  input  wire logic                   clk_i,
  input  wire fir16_pkg::mac_ctrl_t   ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [ACC_W-1:0]       coef_i,    // sign-extended coefficient
  output logic      [ACC_W-1:0]       acc_o
);

  logic [SAMPLE_BITS-1:0] sbits_q, sbits_d;
  logic [ACC_W-1:0]       mcand_q, mcand_d;
  logic [ACC_W-1:0]       acc_q, acc_d;

  always_comb begin
    sbits_d = sbits_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.step && sbits_q[0]) begin
      acc_d = acc_q + mcand_q;
    end
    if (ctrl_i.load) begin
      sbits_d = sample_i;
      mcand_d = coef_i;
    end else if (ctrl_i.step) begin
      sbits_d = sbits_q >> 1;
      mcand_d = mcand_q << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    sbits_q <= sbits_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire
